/* design/assert_macros.svh */
// Assertion macros shared by the sorter files.
// No dependencies; included inside the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define CHECK_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define CHECK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* design/dms_pkg.sv */
// Shared types and constants of the descending merge sorter.
// No dependencies; compiled first.
package dms_pkg;

   localparam int KEY_W  = 32;   // width of key fields on the channels
   localparam int WIDE_W = 64;   // widest supported internal key

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SETUP,
      ST_CHECK,
      ST_SORT_RD,
      ST_SORT_WR,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic load;         // store one request key
      logic setup;        // start a sort over the stored keys
      logic merge_start;  // load run pointers for the next merge
      logic merge_rd;     // read both run heads
      logic merge_wr;     // write the larger head, advance pointers
      logic emit_rd;      // read the next sorted key
      logic emit_next;    // result taken, advance or finish
   } cmd_type;

   typedef struct packed {
      logic sort_done;    // run width covers the whole set
      logic merge_end;    // this write completes the current merge
      logic emit_last;    // the key being emitted is the final one
   } status_type;

endpackage

/* design/dms_channel_if.sv */
// Request and result channel interfaces of the sorter.
// Depends on dms_pkg for the key width.
interface dms_req_if import dms_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] key;
   logic                    last_in;

   modport source (output valid, output key, output last_in, input ready);
   modport sink   (input valid, input key, input last_in, output ready);
endinterface

interface dms_rsp_if import dms_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] sorted_key;
   logic                    last_out;
   logic                    overflow;

   modport source (output valid, output sorted_key, output last_out, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_key, input last_out, input overflow,
                   output ready);
endinterface

/* design/dms_ram.sv */
// Generic RAM: one write port, two read ports with registered data.
// No dependencies.
module dms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

/* design/dms_ctrl.sv */
// Sequencer of the sorter: load, merge passes, emission.
// Depends on dms_pkg for the state, command and status types.
module dms_ctrl import dms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.sort_done) begin
               state_in = ST_EMIT_RD;
            end else begin
               cmd.merge_start = 1'b1;
               state_in        = ST_SORT_RD;
            end
         end
         ST_SORT_RD: begin
            cmd.merge_rd = 1'b1;
            state_in     = ST_SORT_WR;
         end
         ST_SORT_WR: begin
            cmd.merge_wr = 1'b1;
            state_in     = status.merge_end ? ST_CHECK : ST_SORT_RD;
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit_next = 1'b1;
               state_in      = status.emit_last ? ST_LOAD : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

/* design/dms_datapath.sv */
// Datapath of the sorter: two key banks, run pointers, compare and select.
// Depends on dms_pkg and on dms_ram for the banks.
module dms_datapath import dms_pkg::*;
#(
   parameter int CAPACITY = 32,
   parameter int KEY_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic [KEY_W-1:0] req_key,
   output logic [KEY_W-1:0] rsp_key,
   output logic             rsp_last,
   output logic             rsp_overflow
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int SUM_W  = CNT_W + 2;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W:0]   width_ff, width_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] a_ff, a_in;
   logic [CNT_W-1:0] b_ff, b_in;
   logic [CNT_W-1:0] o_ff, o_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             bank_ff, bank_in;

   logic [SUM_W-1:0] n_s, lo_s, w_s, mid_raw, mid_s, hi_raw, hi_s;
   logic             pass_end, a_done, b_done, take_b, has_room;

   logic [WIDE_W-1:0]   key_wide, out_wide;
   logic [KEY_BITS-1:0] load_key, head_a, head_b, merge_key;
   logic [KEY_BITS-1:0] rd_a0, rd_b0, rd_a1, rd_b1;
   logic                we0, we1, re0, re1;
   logic [ADDR_W-1:0]   waddr0, raddr_a;
   logic [KEY_BITS-1:0] wdata0;

   // Run bounds of the current merge, clamped to the set size.
   always_comb begin
      n_s      = SUM_W'(count_ff);
      lo_s     = SUM_W'(lo_ff);
      w_s      = SUM_W'(width_ff);
      mid_raw  = lo_s + w_s;
      hi_raw   = lo_s + (w_s << 1);
      mid_s    = (mid_raw > n_s) ? n_s : mid_raw;
      hi_s     = (hi_raw > n_s) ? n_s : hi_raw;
      pass_end = (hi_raw >= n_s);
      a_done   = (SUM_W'(a_ff) >= mid_s);
      b_done   = (SUM_W'(b_ff) >= hi_s);
      has_room = (SUM_W'(count_ff) < SUM_W'(CAPACITY));
   end

   assign status.sort_done = (w_s >= n_s);
   assign status.merge_end = ((SUM_W'(o_ff) + SUM_W'(1)) == hi_s);
   assign status.emit_last = ((SUM_W'(idx_ff) + SUM_W'(1)) == n_s);

   // Source bank heads; run two wins on a strictly larger key or once run one is done.
   assign head_a    = bank_ff ? rd_a1 : rd_a0;
   assign head_b    = bank_ff ? rd_b1 : rd_b0;
   assign take_b    = a_done || (!b_done && ($signed(head_a) < $signed(head_b)));
   assign merge_key = take_b ? head_b : head_a;

   assign key_wide = WIDE_W'(req_key);
   assign load_key = key_wide[KEY_BITS-1:0];
   assign out_wide = WIDE_W'(head_a);

   assign rsp_key      = out_wide[KEY_W-1:0];
   assign rsp_last     = status.emit_last;
   assign rsp_overflow = ovf_ff;

   // Bank 0 takes loads and the merges out of bank 1; bank 1 the merges out of bank 0.
   assign we0     = (cmd.load && has_room) || (cmd.merge_wr && bank_ff);
   assign waddr0  = cmd.load ? count_ff[ADDR_W-1:0] : o_ff[ADDR_W-1:0];
   assign wdata0  = cmd.load ? load_key : merge_key;
   assign we1     = cmd.merge_wr && !bank_ff;
   assign re0     = (cmd.merge_rd || cmd.emit_rd) && !bank_ff;
   assign re1     = (cmd.merge_rd || cmd.emit_rd) && bank_ff;
   assign raddr_a = cmd.emit_rd ? idx_ff[ADDR_W-1:0] : a_ff[ADDR_W-1:0];

   dms_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_bank (
      .clock     (clock),
      .wr_en     (we0),
      .wr_addr   (waddr0),
      .wr_data   (wdata0),
      .rd_en     (re0),
      .rd_addr_a (raddr_a),
      .rd_addr_b (b_ff[ADDR_W-1:0]),
      .rd_data_a (rd_a0),
      .rd_data_b (rd_b0)
   );

   dms_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_scratch_bank (
      .clock     (clock),
      .wr_en     (we1),
      .wr_addr   (o_ff[ADDR_W-1:0]),
      .wr_data   (merge_key),
      .rd_en     (re1),
      .rd_addr_a (raddr_a),
      .rd_addr_b (b_ff[ADDR_W-1:0]),
      .rd_data_a (rd_a1),
      .rd_data_b (rd_b1)
   );

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      width_in = width_ff;
      lo_in    = lo_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      o_in     = o_ff;
      idx_in   = idx_ff;
      bank_in  = bank_ff;
      if (cmd.load) begin
         if (has_room) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.setup) begin
         width_in = (CNT_W + 1)'(1);
         lo_in    = '0;
         idx_in   = '0;
         bank_in  = 1'b0;
      end
      if (cmd.merge_start) begin
         a_in = lo_ff;
         b_in = mid_s[CNT_W-1:0];
         o_in = lo_ff;
      end
      if (cmd.merge_wr) begin
         o_in = o_ff + CNT_W'(1);
         if (take_b) begin
            b_in = b_ff + CNT_W'(1);
         end else begin
            a_in = a_ff + CNT_W'(1);
         end
         if (status.merge_end) begin
            if (pass_end) begin
               lo_in    = '0;
               width_in = width_ff << 1;
               bank_in  = !bank_ff;
            end else begin
               lo_in = hi_raw[CNT_W-1:0];
            end
         end
      end
      if (cmd.emit_next) begin
         if (status.emit_last) begin
            count_in = '0;
            ovf_in   = 1'b0;
            idx_in   = '0;
         end else begin
            idx_in = idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         width_ff <= '0;
         lo_ff    <= '0;
         a_ff     <= '0;
         b_ff     <= '0;
         o_ff     <= '0;
         idx_ff   <= '0;
         bank_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         width_ff <= width_in;
         lo_ff    <= lo_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         o_ff     <= o_in;
         idx_ff   <= idx_in;
         bank_ff  <= bank_in;
      end
   end

`include "assert_macros.svh"

   // A write always lands inside the current output run.
   `CHECK_NOW(a_write_in_run, clock, reset, cmd.merge_wr, SUM_W'(o_ff) < hi_s)
   // Emission only happens over stored keys.
   `CHECK_NOW(a_emit_in_set, clock, reset, cmd.emit_rd, SUM_W'(idx_ff) < n_s)

endmodule

/* design/descending_merge_sort.sv */
// Top level of the descending merge sorter.
// Depends on dms_pkg, the channel interfaces, dms_ctrl and dms_datapath.
//
// Usage: send keys on req_chan one request per key; the request with last_in set
// closes the set (its key is stored too if there is room). Keys beyond CAPACITY
// are dropped and the overflow bit is raised on every result of that set.
// After the closing request the block sorts the set and returns it on rsp_chan
// in descending signed order, one result per stored key, last_out on the final one.
// req_chan.ready is high only while keys are being loaded; a key is taken whenever valid is high.
// Sorting runs ceil(log2 n) merge passes over two banks; each output element of a
// pass reads both run heads and then writes the larger one through the shared
// compare unit, and each merge starts with a step that loads the run pointers.
// Emission reads each key from the bank (a registered read) and then presents it;
// the next key is read only after the current result is taken.
// A stalled receiver holds the current result and the block simply waits.
// Reset (synchronous, active high) empties the store and clears the overflow
// flag; the banks themselves need no clearing since only loaded entries are read.
module descending_merge_sort import dms_pkg::*;
#(
   parameter int CAPACITY = 32,
   parameter int KEY_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   dms_req_if.sink   req_chan,
   dms_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;
   logic [KEY_W-1:0] rsp_key;
   logic             close_accept;

   // Sequencer: owns both handshakes.
   dms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_in),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: banks, pointers and the compare unit.
   dms_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_key      (req_chan.key),
      .rsp_key      (rsp_key),
      .rsp_last     (rsp_chan.last_out),
      .rsp_overflow (rsp_chan.overflow)
   );

   assign rsp_chan.sorted_key = rsp_key;

   // Closing request of a set taken this cycle.
   assign close_accept = req_chan.valid && req_chan.ready && req_chan.last_in;

`include "assert_macros.svh"

   // Never load and emit at the same time.
   `CHECK_NOW(a_no_overlap, clock, reset, rsp_chan.valid, !req_chan.ready)
   // The closing request is never answered in the same or the next cycle.
   `CHECK_NEXT(a_sort_gap, clock, reset, close_accept, !rsp_chan.valid)
   // Taking the final result reopens loading.
   `CHECK_NEXT(a_reopen, clock, reset, rsp_chan.valid && rsp_chan.ready && rsp_chan.last_out, req_chan.ready)

endmodule
